### hdl/nrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrf_pkg
// Types and constants shared by the nearest-return follow controller.
// ----------------------------------------------------------------------------
package nrf_pkg;

    // one lidar sample
    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_sample;
    } t_in;

    // one follow command
    typedef struct packed {
        logic signed [15:0] angular_cmd;
        logic signed [15:0] linear_cmd;
        logic               in_range;
    } t_out;

    // configuration registers as seen by the command engine
    typedef struct packed {
        logic        [15:0] target_distance;
        logic signed [15:0] target_angle;
        logic signed [15:0] angle_gain;
        logic signed [15:0] distance_gain;
        logic signed [15:0] scan_start_angle;
        logic        [15:0] scan_step_angle;
    } t_cfg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DISTANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP_ANGLE  = 3'd5;

    localparam logic [15:0] RST_TARGET_DISTANCE  = 16'd200;
    localparam logic [15:0] RST_TARGET_ANGLE     = 16'd0;
    localparam logic [15:0] RST_ANGLE_GAIN       = 16'd4096;
    localparam logic [15:0] RST_DISTANCE_GAIN    = 16'd2048;
    localparam logic [15:0] RST_SCAN_START_ANGLE = 16'h9B78;  // -25736
    localparam logic [15:0] RST_SCAN_STEP_ANGLE  = 16'd18301;

    localparam logic [15:0] MIN_VALID_MM = 16'd200;
    localparam logic [15:0] NO_RETURN_MM = 16'hFFFF;
    localparam logic [15:0] FAR_LIMIT_MM = 16'd12000;

    localparam int HALF_PI_Q20 = 1647099;
    localparam int ROUND_Q7    = 64;
    localparam int ROUND_Q12   = 2048;
    localparam int SAT_MAX     = 32767;
    localparam int SAT_MIN     = -32768;

endpackage

### hdl/nrf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrf_front
// Per-sample nearest-return tracker; queues one job per scan with a hit.
// ----------------------------------------------------------------------------
module nrf_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int POS_W       = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nrf_pkg::t_in      i_in_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output logic [16+POS_W-1:0] o_q_data
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SAMPLES - 1);

    logic [15:0]      r_best_range, n_best_range;
    logic [POS_W-1:0] r_best_pos, n_best_pos;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_found, n_found;

    logic             w_accept;
    logic             w_valid_rng;
    logic             w_take;
    logic [15:0]      w_range;
    logic [POS_W-1:0] w_sel_pos;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_range    = i_in_data.range_mm;

    assign w_valid_rng = (w_range >= nrf_pkg::MIN_VALID_MM) &&
                         (w_range != nrf_pkg::NO_RETURN_MM);
    assign w_take      = w_valid_rng && (!r_found || (w_range < r_best_range));

    always_comb begin
        n_best_range = r_best_range;
        n_best_pos   = r_best_pos;
        n_pos        = r_pos;
        n_found      = r_found;
        o_q_push     = 1'b0;
        w_sel_pos    = r_best_pos;
        if (w_accept) begin
            if (w_take) begin
                n_best_range = w_range;
                w_sel_pos    = r_pos;
                n_found      = 1'b1;
            end
            n_best_pos = w_sel_pos;
            if (r_pos != POS_LAST) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (i_in_data.last_sample) begin
                // end of scan: emit a job only when something was seen
                o_q_push     = n_found;
                n_best_range = '0;
                n_best_pos   = '0;
                n_pos        = '0;
                n_found      = 1'b0;
            end
        end
    end

    assign o_q_data = {(w_take ? w_range : r_best_range), w_sel_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_range <= '0;
            r_best_pos   <= '0;
            r_pos        <= '0;
            r_found      <= 1'b0;
        end else begin
            r_best_range <= n_best_range;
            r_best_pos   <= n_best_pos;
            r_pos        <= n_pos;
            r_found      <= n_found;
        end
    end

endmodule

### hdl/nrf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrf_fifo
// Small register queue between the sample tracker and the command engine.
// ----------------------------------------------------------------------------
module nrf_fifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### hdl/nrf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrf_back
// Command engine: bearing, error products, rounding and saturation.
// ----------------------------------------------------------------------------
module nrf_back #(
    parameter int POS_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nrf_pkg::t_cfg       i_cfg,
    input  logic                i_q_valid,
    input  logic [16+POS_W-1:0] i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nrf_pkg::t_out       o_out_data
);

    localparam int PROD_W = 16 + POS_W;
    localparam int B_W    = ((PROD_W > 24) ? PROD_W : 24) + 2;
    localparam int BR_W   = B_W - 7;
    localparam int DF_W   = BR_W + 1;
    localparam int AW     = DF_W + 16;
    localparam int LW     = 33;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_POS  = 5'b00010,
        ST_BEAR = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic        [15:0]       r_range;
    logic        [POS_W-1:0]  r_pos;
    logic        [PROD_W-1:0] r_prod;
    logic signed [DF_W-1:0]   r_diff;
    logic signed [16:0]       r_dist;
    logic signed [AW-1:0]     r_ang;
    logic signed [LW-1:0]     r_lin;
    logic                     r_out_valid;
    nrf_pkg::t_out            r_out;

    logic signed [B_W-1:0]  w_start_ext;
    logic signed [B_W-1:0]  w_prod_ext;
    logic signed [B_W-1:0]  w_b20;
    logic signed [B_W-1:0]  w_bear_sh;
    logic signed [DF_W-1:0] w_bear;
    logic signed [DF_W-1:0] w_tgt_ang;
    logic signed [AW-1:0]   w_ang_sh;
    logic signed [LW-1:0]   w_lin_sh;
    logic signed [15:0]     w_ang_sat;
    logic signed [15:0]     w_lin_sat;
    logic                   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    // bearing in Q20, rounded to the nearest Q13
    assign w_start_ext = {{(B_W-16){i_cfg.scan_start_angle[15]}}, i_cfg.scan_start_angle};
    assign w_prod_ext  = {{(B_W-PROD_W){1'b0}}, r_prod};
    assign w_b20       = (w_start_ext <<< 7) + w_prod_ext - B_W'(nrf_pkg::HALF_PI_Q20)
                         + B_W'(nrf_pkg::ROUND_Q7);
    assign w_bear_sh   = w_b20 >>> 7;
    assign w_bear      = {w_bear_sh[BR_W-1], w_bear_sh[BR_W-1:0]};
    assign w_tgt_ang   = {{(DF_W-16){i_cfg.target_angle[15]}}, i_cfg.target_angle};

    assign w_ang_sh = (r_ang + AW'(nrf_pkg::ROUND_Q12)) >>> 12;
    assign w_lin_sh = (r_lin + LW'(nrf_pkg::ROUND_Q12)) >>> 12;

    always_comb begin
        if (w_ang_sh > AW'(nrf_pkg::SAT_MAX)) begin
            w_ang_sat = 16'sh7FFF;
        end else if (w_ang_sh < AW'(nrf_pkg::SAT_MIN)) begin
            w_ang_sat = 16'sh8000;
        end else begin
            w_ang_sat = w_ang_sh[15:0];
        end
        if (w_lin_sh > LW'(nrf_pkg::SAT_MAX)) begin
            w_lin_sat = 16'sh7FFF;
        end else if (w_lin_sh < LW'(nrf_pkg::SAT_MIN)) begin
            w_lin_sat = 16'sh8000;
        end else begin
            w_lin_sat = w_lin_sh[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_POS;
                end
            end
            ST_POS:  n_state = ST_BEAR;
            ST_BEAR: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_range <= i_q_data[PROD_W-1:POS_W];
            r_pos   <= i_q_data[POS_W-1:0];
        end
        if (r_state == ST_POS) begin
            r_prod <= PROD_W'(i_cfg.scan_step_angle) * PROD_W'(r_pos);
        end
        if (r_state == ST_BEAR) begin
            r_diff <= w_bear - w_tgt_ang;
            r_dist <= $signed({1'b0, r_range}) - $signed({1'b0, i_cfg.target_distance});
        end
        if (r_state == ST_MUL) begin
            r_ang <= AW'(i_cfg.angle_gain) * AW'(r_diff);
            r_lin <= LW'(i_cfg.distance_gain) * LW'(r_dist);
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            if (r_range < nrf_pkg::FAR_LIMIT_MM) begin
                r_out.angular_cmd <= w_ang_sat;
                r_out.linear_cmd  <= w_lin_sat;
                r_out.in_range    <= 1'b1;
            end else begin
                // far return: hold still
                r_out.angular_cmd <= '0;
                r_out.linear_cmd  <= '0;
                r_out.in_range    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/nearest_return_follow_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_return_follow_controller_top
// Lidar nearest-return follower producing turn and speed commands per scan.
// ----------------------------------------------------------------------------
// Samples are taken at one word per clock unless the input stalls: the
// tracker does a single range compare per sample. At the sample marked last,
// a scan that held a valid return queues a job in a two-entry queue; the
// command engine turns it in registered steps (step multiply, bearing add, two
// gain multiplies, round and saturate) into a command in an output register.
// The input stalls only while that queue is full, which happens only for scans
// of a few samples each outpacing the engine or while the output side stalls.
module nearest_return_follow_controller_top #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  nrf_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nrf_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [nrf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [15:0]                        i_cfg_data
);

    localparam int POS_W = $clog2(MAX_SAMPLES);
    localparam int JOB_W = 16 + POS_W;

    nrf_pkg::t_cfg    r_cfg;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_q_valid;
    logic [JOB_W-1:0] w_push_data;
    logic [JOB_W-1:0] w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_distance  <= nrf_pkg::RST_TARGET_DISTANCE;
            r_cfg.target_angle     <= nrf_pkg::RST_TARGET_ANGLE;
            r_cfg.angle_gain       <= nrf_pkg::RST_ANGLE_GAIN;
            r_cfg.distance_gain    <= nrf_pkg::RST_DISTANCE_GAIN;
            r_cfg.scan_start_angle <= nrf_pkg::RST_SCAN_START_ANGLE;
            r_cfg.scan_step_angle  <= nrf_pkg::RST_SCAN_STEP_ANGLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nrf_pkg::CFG_TARGET_DISTANCE:  r_cfg.target_distance  <= i_cfg_data;
                nrf_pkg::CFG_TARGET_ANGLE:     r_cfg.target_angle     <= i_cfg_data;
                nrf_pkg::CFG_ANGLE_GAIN:       r_cfg.angle_gain       <= i_cfg_data;
                nrf_pkg::CFG_DISTANCE_GAIN:    r_cfg.distance_gain    <= i_cfg_data;
                nrf_pkg::CFG_SCAN_START_ANGLE: r_cfg.scan_start_angle <= i_cfg_data;
                nrf_pkg::CFG_SCAN_STEP_ANGLE:  r_cfg.scan_step_angle  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    nrf_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .POS_W       (POS_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data)
    );

    nrf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    nrf_back #(
        .POS_W (POS_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_pop_data),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // a scan job is never dropped at the queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("scan job pushed into full queue");

    // far returns give zero commands
    a_far_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.in_range) |->
        (o_out_data.angular_cmd == 16'sd0 && o_out_data.linear_cmd == 16'sd0))
        else $error("nonzero command with in_range low");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled command changed");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-return follow controller. Lidar scans
// stream in over the valid/stall input while the output side stalls at
// random. A scan tracker in the bench predicts the follow command for each
// scan, and every accepted output word is checked against it in order.
// Registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCAN_LIMIT   = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 80;

    localparam logic [nrf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [nrf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    nrf_pkg::t_in                  i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    nrf_pkg::t_out                 o_out_data;
    logic                          i_cfg_we = 1'b0;
    logic [nrf_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0]                   i_cfg_data = '0;

    nearest_return_follow_controller_top #(
        .MAX_SAMPLES(SCAN_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    nrf_pkg::t_in  sample_queue[$];
    nrf_pkg::t_out cmd_expected[$];
    int   mismatch_count = 0;
    int   send_idle_pct = 25;
    int   recv_stall_pct = 80;
    bit   hold_armed = 1'b0;
    logic receiver_hold = 1'b0;

    // bench copy of the registers
    logic        [15:0] cfg_target_distance;
    logic signed [15:0] cfg_target_angle;
    logic signed [15:0] cfg_angle_gain;
    logic signed [15:0] cfg_distance_gain;
    logic signed [15:0] cfg_start_angle;
    logic        [15:0] cfg_step_angle;

    // scan tracker state
    logic [15:0] trk_best;
    logic [10:0] trk_best_pos;
    logic [10:0] trk_pos;
    bit          trk_found;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > nrf_pkg::SAT_MAX) return 16'sh7FFF;
        if (v < nrf_pkg::SAT_MIN) return 16'sh8000;
        return v[15:0];
    endfunction

    // nearest-return tracking; returns 1 when the word closes a scan with a hit
    function automatic bit track_sample(input nrf_pkg::t_in w, output nrf_pkg::t_out cmd);
        longint b20;
        longint bearing;
        longint ang;
        longint lin;
        bit     emit;
        emit = 1'b0;
        cmd  = '0;
        if (w.range_mm >= nrf_pkg::MIN_VALID_MM && w.range_mm != nrf_pkg::NO_RETURN_MM &&
            (!trk_found || w.range_mm < trk_best)) begin
            trk_best     = w.range_mm;
            trk_best_pos = trk_pos;
            trk_found    = 1'b1;
        end
        if (trk_pos < SCAN_LIMIT - 1) trk_pos = trk_pos + 1'b1;
        if (w.last_sample) begin
            if (trk_found) begin
                emit = 1'b1;
                if (trk_best < nrf_pkg::FAR_LIMIT_MM) begin
                    b20 = longint'(cfg_start_angle) * 128
                        + longint'(cfg_step_angle) * longint'(trk_best_pos)
                        - nrf_pkg::HALF_PI_Q20;
                    bearing = (b20 + nrf_pkg::ROUND_Q7) >>> 7;
                    ang = longint'(cfg_angle_gain) * (bearing - longint'(cfg_target_angle));
                    lin = longint'(cfg_distance_gain)
                        * (longint'(trk_best) - longint'(cfg_target_distance));
                    cmd.angular_cmd = sat16((ang + nrf_pkg::ROUND_Q12) >>> 12);
                    cmd.linear_cmd  = sat16((lin + nrf_pkg::ROUND_Q12) >>> 12);
                    cmd.in_range    = 1'b1;
                end
            end
            trk_best     = '0;
            trk_best_pos = '0;
            trk_pos      = '0;
            trk_found    = 1'b0;
        end
        return emit;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= sample_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= receiver_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off, armed once by the stimulus
    initial begin
        wait (hold_armed);
        @(posedge i_clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        receiver_hold <= 1'b0;
    end

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    // monitor: register writes, accepted samples and accepted commands
    always @(posedge i_clk) begin
        nrf_pkg::t_out want;
        nrf_pkg::t_out got;
        if (!i_rst_n) begin
            cfg_target_distance = nrf_pkg::RST_TARGET_DISTANCE;
            cfg_target_angle    = nrf_pkg::RST_TARGET_ANGLE;
            cfg_angle_gain      = nrf_pkg::RST_ANGLE_GAIN;
            cfg_distance_gain   = nrf_pkg::RST_DISTANCE_GAIN;
            cfg_start_angle     = nrf_pkg::RST_SCAN_START_ANGLE;
            cfg_step_angle      = nrf_pkg::RST_SCAN_STEP_ANGLE;
            trk_best     = '0;
            trk_best_pos = '0;
            trk_pos      = '0;
            trk_found    = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nrf_pkg::CFG_TARGET_DISTANCE:  cfg_target_distance = i_cfg_data;
                    nrf_pkg::CFG_TARGET_ANGLE:     cfg_target_angle    = i_cfg_data;
                    nrf_pkg::CFG_ANGLE_GAIN:       cfg_angle_gain      = i_cfg_data;
                    nrf_pkg::CFG_DISTANCE_GAIN:    cfg_distance_gain   = i_cfg_data;
                    nrf_pkg::CFG_SCAN_START_ANGLE: cfg_start_angle     = i_cfg_data;
                    nrf_pkg::CFG_SCAN_STEP_ANGLE:  cfg_step_angle      = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (cmd_expected.size() == 0) begin
                    report($sformatf("unexpected word ang=%0d lin=%0d in_range=%0b",
                                     got.angular_cmd, got.linear_cmd, got.in_range));
                end else begin
                    want = cmd_expected.pop_front();
                    if (got.angular_cmd !== want.angular_cmd ||
                        got.linear_cmd !== want.linear_cmd ||
                        got.in_range !== want.in_range) begin
                        report($sformatf({"mismatch exp ang=%0d lin=%0d in_range=%0b",
                                          " got ang=%0d lin=%0d in_range=%0b"},
                                         want.angular_cmd, want.linear_cmd, want.in_range,
                                         got.angular_cmd, got.linear_cmd, got.in_range));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (track_sample(i_in_data, want)) cmd_expected.push_back(want);
            end
        end
    end

    task automatic push_sample(input logic [15:0] range_mm, input bit last);
        nrf_pkg::t_in w;
        w.range_mm    = range_mm;
        w.last_sample = last;
        sample_queue.push_back(w);
    endtask

    function automatic logic [15:0] pick_range();
        int r;
        r = $urandom_range(99);
        if (r < 15) return nrf_pkg::NO_RETURN_MM;
        if (r < 25) return 16'($urandom_range(199));
        if (r < 35) begin
            case ($urandom_range(6))
                0: return 16'd199;
                1: return 16'd200;
                2: return 16'd201;
                3: return 16'd11999;
                4: return 16'd12000;
                5: return 16'd12001;
                default: return 16'd65534;
            endcase
        end
        if (r < 60) return 16'($urandom);
        return 16'($urandom_range(11999, 200));
    endfunction

    // random scans, mostly short so commands come often
    task automatic add_scans(input int words);
        int len;
        int n;
        n = 0;
        while (n < words) begin
            len = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(48, 9);
            for (int k = 0; k < len; k++) push_sample(pick_range(), k == len - 1);
            n += len;
        end
    endtask

    task automatic cfg_write(input logic [nrf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic apply_config(input logic [15:0] tdist, input logic [15:0] tang,
                                input logic [15:0] again, input logic [15:0] dgain,
                                input logic [15:0] start, input logic [15:0] step);
        cfg_write(nrf_pkg::CFG_TARGET_DISTANCE, tdist);
        cfg_write(nrf_pkg::CFG_TARGET_ANGLE, tang);
        cfg_write(nrf_pkg::CFG_ANGLE_GAIN, again);
        cfg_write(nrf_pkg::CFG_DISTANCE_GAIN, dgain);
        cfg_write(nrf_pkg::CFG_SCAN_START_ANGLE, start);
        cfg_write(nrf_pkg::CFG_SCAN_STEP_ANGLE, step);
        // unused indexes must leave every register alone
        cfg_write($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sample_queue.size() > 0 || i_in_valid || cmd_expected.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: validity bounds, ties, empty scans, far returns
        push_sample(16'd150, 1'b0);
        push_sample(16'd199, 1'b0);
        push_sample(16'd200, 1'b1);
        push_sample(16'd0, 1'b0);
        push_sample(nrf_pkg::NO_RETURN_MM, 1'b1);
        push_sample(16'd500, 1'b0);
        push_sample(16'd300, 1'b0);
        push_sample(16'd300, 1'b1);
        push_sample(16'd12000, 1'b1);
        push_sample(16'd11999, 1'b1);
        push_sample(16'd65534, 1'b1);
        push_sample(nrf_pkg::NO_RETURN_MM, 1'b1);
        push_sample(16'd201, 1'b0);
        push_sample(nrf_pkg::NO_RETURN_MM, 1'b0);
        push_sample(16'd200, 1'b1);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            if (p < 4) begin
                send_idle_pct  = 25;
                recv_stall_pct = 80;
            end else if (p < 7) begin
                send_idle_pct  = 80;
                recv_stall_pct = 25;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (p)
                0: apply_config(16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
                1: apply_config(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
                4: apply_config(nrf_pkg::RST_TARGET_DISTANCE, nrf_pkg::RST_TARGET_ANGLE,
                                nrf_pkg::RST_ANGLE_GAIN, nrf_pkg::RST_DISTANCE_GAIN,
                                nrf_pkg::RST_SCAN_START_ANGLE,
                                nrf_pkg::RST_SCAN_STEP_ANGLE);
                default: begin
                    if ($urandom_range(1))
                        apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom));
                    else
                        apply_config(16'($urandom_range(3000)),
                                     16'($urandom_range(8000) - 4000),
                                     16'($urandom_range(16384) - 8192),
                                     16'($urandom_range(16384) - 8192),
                                     16'($urandom_range(8000) - 28000),
                                     16'($urandom_range(40000)));
                end
            endcase
            if (p == 4) begin
                // scan longer than the index range: late samples share the top index
                for (int k = 0; k < 1030; k++) begin
                    case (k)
                        500:  push_sample(16'd5000, 1'b0);
                        1023: push_sample(16'd3000, 1'b0);
                        1025: push_sample(16'd3000, 1'b0);
                        1028: push_sample(16'd2999, 1'b0);
                        default: push_sample(nrf_pkg::NO_RETURN_MM, k == 1029);
                    endcase
                end
            end
            if (p == 8) begin
                // one-word scans behind a stalled receiver back the block up
                hold_armed = 1'b1;
                for (int k = 0; k < 150; k++)
                    push_sample(16'($urandom_range(11999, 200)), 1'b1);
            end
            add_scans(PHASE_WORDS);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
